### src/sm83r3_pkg.sv
// Shared types and constants for the SM83 row 0x30-0x3F execute block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sm83r3_pkg;

  // Low nibble of the opcode selects the instruction.
  typedef enum logic [3:0] {
    OP_JR_NC     = 4'h0,
    OP_LD_SP_D16 = 4'h1,
    OP_LD_HLD_A  = 4'h2,
    OP_INC_SP    = 4'h3,
    OP_INC_MHL   = 4'h4,
    OP_DEC_MHL   = 4'h5,
    OP_LD_MHL_D8 = 4'h6,
    OP_SCF       = 4'h7,
    OP_UNSUP     = 4'h8,
    OP_ADD_HL_SP = 4'h9,
    OP_LD_A_HLD  = 4'hA,
    OP_DEC_SP    = 4'hB,
    OP_INC_A     = 4'hC,
    OP_DEC_A     = 4'hD,
    OP_LD_A_D8   = 4'hE,
    OP_CCF       = 4'hF
  } op_e;

  // Flag bit positions.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [3:0] CYC_4  = 4'd4;
  localparam logic [3:0] CYC_8  = 4'd8;
  localparam logic [3:0] CYC_12 = 4'd12;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 96;

  typedef struct packed {
    logic [5:0] func;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] mem_at_hl;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
  } arch_state_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic [3:0]  cycle_count;
    logic        unsupported;
  } mem_side_t;

  typedef struct packed {
    arch_state_t regs;
    mem_side_t   side;
  } result_t;

endpackage

### src/sm83r3_alu.sv
// Combinational execute logic for one instruction of row 0x30-0x3F.
// Depends on sm83r3_pkg for the opcode enum, flag positions and structs.
`timescale 1ns / 1ps

module sm83r3_alu (
  input  sm83r3_pkg::in_item_t    item_i,
  input  sm83r3_pkg::arch_state_t cur_i,
  output sm83r3_pkg::result_t     res_o
);

  function automatic logic [3:0] incdec_flags(input logic [7:0] prev, input logic [7:0] after,
                                              input logic dec, input logic carry);
    logic [3:0] f;
    f                     = '0;
    f[sm83r3_pkg::FLAG_C] = carry;
    f[sm83r3_pkg::FLAG_Z] = (after == 8'h00);
    f[sm83r3_pkg::FLAG_N] = dec;
    f[sm83r3_pkg::FLAG_H] = dec ? (prev[3:0] == 4'h0) : (prev[3:0] == 4'hF);
    return f;
  endfunction

  sm83r3_pkg::op_e         op;
  sm83r3_pkg::arch_state_t nxt;
  sm83r3_pkg::mem_side_t   side;
  logic [15:0]             pc1, pc2, pc3, jr_off;
  logic [7:0]              mem_inc, mem_dec, a_inc, a_dec;
  logic [16:0]             hl_sum;
  logic [12:0]             hl_low_sum;
  logic                    cf;

  assign op         = sm83r3_pkg::op_e'(item_i.func[3:0]);
  assign pc1        = cur_i.pc + 16'd1;
  assign pc2        = cur_i.pc + 16'd2;
  assign pc3        = cur_i.pc + 16'd3;
  assign jr_off     = {{8{item_i.operand_low[7]}}, item_i.operand_low};
  assign mem_inc    = item_i.mem_at_hl + 8'd1;
  assign mem_dec    = item_i.mem_at_hl - 8'd1;
  assign a_inc      = cur_i.a + 8'd1;
  assign a_dec      = cur_i.a - 8'd1;
  assign hl_sum     = {1'b0, cur_i.hl} + {1'b0, cur_i.sp};
  assign hl_low_sum = {1'b0, cur_i.hl[11:0]} + {1'b0, cur_i.sp[11:0]};
  assign cf         = cur_i.flags[sm83r3_pkg::FLAG_C];

  always_comb begin
    nxt                = cur_i;
    side.write_enable  = 1'b0;
    side.write_address = 16'h0000;
    side.write_byte    = 8'h00;
    side.cycle_count   = sm83r3_pkg::CYC_4;
    side.unsupported   = 1'b0;
    case (op)
      sm83r3_pkg::OP_JR_NC: begin
        if (!cf) begin
          nxt.pc           = pc2 + jr_off;
          side.cycle_count = sm83r3_pkg::CYC_12;
        end else begin
          nxt.pc           = pc2;
          side.cycle_count = sm83r3_pkg::CYC_8;
        end
      end
      sm83r3_pkg::OP_LD_SP_D16: begin
        nxt.sp           = {item_i.operand_high, item_i.operand_low};
        nxt.pc           = pc3;
        side.cycle_count = sm83r3_pkg::CYC_12;
      end
      sm83r3_pkg::OP_LD_HLD_A: begin
        side.write_enable  = 1'b1;
        side.write_address = cur_i.hl;
        side.write_byte    = cur_i.a;
        nxt.hl             = cur_i.hl - 16'd1;
        nxt.pc             = pc1;
        side.cycle_count   = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_INC_SP: begin
        nxt.sp           = cur_i.sp + 16'd1;
        nxt.pc           = pc1;
        side.cycle_count = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_INC_MHL: begin
        nxt.flags          = incdec_flags(item_i.mem_at_hl, mem_inc, 1'b0, cf);
        side.write_enable  = 1'b1;
        side.write_address = cur_i.hl;
        side.write_byte    = mem_inc;
        nxt.pc             = pc1;
        side.cycle_count   = sm83r3_pkg::CYC_12;
      end
      sm83r3_pkg::OP_DEC_MHL: begin
        nxt.flags          = incdec_flags(item_i.mem_at_hl, mem_dec, 1'b1, cf);
        side.write_enable  = 1'b1;
        side.write_address = cur_i.hl;
        side.write_byte    = mem_dec;
        nxt.pc             = pc1;
        side.cycle_count   = sm83r3_pkg::CYC_12;
      end
      sm83r3_pkg::OP_LD_MHL_D8: begin
        side.write_enable  = 1'b1;
        side.write_address = cur_i.hl;
        side.write_byte    = item_i.operand_low;
        nxt.pc             = pc2;
        side.cycle_count   = sm83r3_pkg::CYC_12;
      end
      sm83r3_pkg::OP_SCF: begin
        nxt.flags                     = '0;
        nxt.flags[sm83r3_pkg::FLAG_Z] = cur_i.flags[sm83r3_pkg::FLAG_Z];
        nxt.flags[sm83r3_pkg::FLAG_C] = 1'b1;
        nxt.pc                        = pc1;
      end
      sm83r3_pkg::OP_UNSUP: begin
        // leave every register as it is, PC included
        side.unsupported = 1'b1;
      end
      sm83r3_pkg::OP_ADD_HL_SP: begin
        nxt.hl                        = hl_sum[15:0];
        nxt.flags                     = '0;
        nxt.flags[sm83r3_pkg::FLAG_Z] = cur_i.flags[sm83r3_pkg::FLAG_Z];
        nxt.flags[sm83r3_pkg::FLAG_H] = hl_low_sum[12];
        nxt.flags[sm83r3_pkg::FLAG_C] = hl_sum[16];
        nxt.pc                        = pc1;
        side.cycle_count              = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_LD_A_HLD: begin
        nxt.a            = item_i.mem_at_hl;
        nxt.hl           = cur_i.hl - 16'd1;
        nxt.pc           = pc1;
        side.cycle_count = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_DEC_SP: begin
        nxt.sp           = cur_i.sp - 16'd1;
        nxt.pc           = pc1;
        side.cycle_count = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_INC_A: begin
        nxt.flags = incdec_flags(cur_i.a, a_inc, 1'b0, cf);
        nxt.a     = a_inc;
        nxt.pc    = pc1;
      end
      sm83r3_pkg::OP_DEC_A: begin
        nxt.flags = incdec_flags(cur_i.a, a_dec, 1'b1, cf);
        nxt.a     = a_dec;
        nxt.pc    = pc1;
      end
      sm83r3_pkg::OP_LD_A_D8: begin
        nxt.a            = item_i.operand_low;
        nxt.pc           = pc2;
        side.cycle_count = sm83r3_pkg::CYC_8;
      end
      sm83r3_pkg::OP_CCF: begin
        nxt.flags                     = '0;
        nxt.flags[sm83r3_pkg::FLAG_Z] = cur_i.flags[sm83r3_pkg::FLAG_Z];
        nxt.flags[sm83r3_pkg::FLAG_C] = ~cf;
        nxt.pc                        = pc1;
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  assign res_o.regs = nxt;
  assign res_o.side = side;

endmodule

### src/sm83r3_regs.sv
// Architectural register file: A, HL, SP, PC and the Z/N/H/C flags.
// Depends on sm83r3_pkg for the state struct.
`timescale 1ns / 1ps

module sm83r3_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  sm83r3_pkg::arch_state_t state_d_i,
  output sm83r3_pkg::arch_state_t state_o
);

  sm83r3_pkg::arch_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (we_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_o = state_q;

endmodule

### src/sm83_row3_execute.sv
// SM83 row 0x30-0x3F execute block, top level.
// Uses sm83r3_pkg, sm83r3_alu and sm83r3_regs.
//
// Usage:
//   Slave channel s_axis_*: one beat per instruction, carrying the opcode, the
//   two bytes after it and the byte at HL. Master channel m_axis_*: one beat
//   per instruction with A, HL, SP, PC, flags, an optional store and the
//   cycle count; tuser marks the unsupported opcode.
//   Path: an accepted beat lands in the input register, is executed against
//   the register file and is loaded into the result register, from which
//   it shows on m_axis.
//   Throughput is one instruction per clock while m_axis_tready_i is high: the
//   register file and the result register load at the same edge, so the next
//   instruction in the input register already sees the updated state.
//   Stall: while the result register is full and not taken, the input
//   register holds and s_axis_tready_o drops once it is occupied; no beat is
//   lost or repeated.
//   Reset: rst_ni clears both valid flags and all architectural registers
//   to zero.
`timescale 1ns / 1ps

module sm83_row3_execute (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // func[5:0], operand_low[13:6], operand_high[21:14], mem_at_hl[29:22], zero pad
  input  logic [sm83r3_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // reg_a[7:0], reg_hl[23:8], reg_sp[39:24], reg_pc[55:40], flag_bits[59:56],
  // write_enable[60], write_address[76:61], write_byte[84:77],
  // cycle_count[88:85], zero pad
  output logic [sm83r3_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // unsupported[0]
  output logic                                  m_axis_tuser_o
);

  logic                    in_valid_q;
  sm83r3_pkg::in_item_t    in_q, in_d;
  logic                    out_valid_q;
  sm83r3_pkg::result_t     out_q;
  sm83r3_pkg::result_t     exec_res;
  sm83r3_pkg::arch_state_t cur_state;
  logic                    advance, in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_d.func         = s_axis_tdata_i[5:0];
  assign in_d.operand_low  = s_axis_tdata_i[13:6];
  assign in_d.operand_high = s_axis_tdata_i[21:14];
  assign in_d.mem_at_hl    = s_axis_tdata_i[29:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
  end

  sm83r3_alu u_alu (
    .item_i (in_q),
    .cur_i  (cur_state),
    .res_o  (exec_res)
  );

  // commit state at the same edge the result is captured
  sm83r3_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (advance),
    .state_d_i (exec_res.regs),
    .state_o   (cur_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= exec_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0,
                            out_q.side.cycle_count,
                            out_q.side.write_byte,
                            out_q.side.write_address,
                            out_q.side.write_enable,
                            out_q.regs.flags,
                            out_q.regs.pc,
                            out_q.regs.sp,
                            out_q.regs.hl,
                            out_q.regs.a};
  assign m_axis_tuser_o  = out_q.side.unsupported;

endmodule

### src/sm83r3_checker.sv
// Port-level checks for the SM83 row 0x30-0x3F execute block.
// Bound to sm83_row3_execute; uses sm83r3_pkg for widths and cycle counts.
`timescale 1ns / 1ps

module sm83r3_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [sm83r3_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                               m_axis_tuser_o
);

  logic [3:0] cyc;
  logic       wen;

  assign cyc = m_axis_tdata_o[88:85];
  assign wen = m_axis_tdata_o[60];

  // stalled result beat holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_cycles_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cyc == sm83r3_pkg::CYC_4) || (cyc == sm83r3_pkg::CYC_8) ||
                        (cyc == sm83r3_pkg::CYC_12))
    else $error("cycle count not 4, 8 or 12");

  a_unsup_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !wen && (cyc == sm83r3_pkg::CYC_4))
    else $error("unsupported opcode stored or took more than 4 cycles");

  a_no_store_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !wen |-> (m_axis_tdata_o[84:61] == 24'h0))
    else $error("store address or byte nonzero without a store");

  // a fresh input beat must pass the input register and the result register before a result can show
  a_empty_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o ##1 !m_axis_tvalid_o)
    else $error("result beat appeared too soon after reset");

endmodule

bind sm83_row3_execute sm83r3_checker u_sm83r3_checker (.*);
